/* design/wpvc_pkg.sv */
// ----------------------------------------------------------------------------
// wpvc_pkg
// Shared types, widths and codes of the windowed PI valve controller.
// ----------------------------------------------------------------------------
package wpvc_pkg;

  // Error window length; must be a power of two (average is a shift).
  localparam int WINDOW_LEN = 8;
  localparam int WIN_LOG2   = $clog2(WINDOW_LEN);
  localparam int IDX_W      = WIN_LOG2;

  localparam int DATA_W     = 16;
  localparam int GAIN_FRAC  = 8;
  localparam int ERR_W      = DATA_W + 1;
  localparam int SUM_W      = ERR_W + WIN_LOG2;
  localparam int GAIN_S_W   = DATA_W + 1;
  localparam int PROD_P_W   = ERR_W + GAIN_S_W;
  localparam int PROD_I_W   = SUM_W + GAIN_S_W;
  localparam int PROD_PS_W  = PROD_P_W + WIN_LOG2;
  localparam int NUM_W      = ((PROD_PS_W > PROD_I_W) ? PROD_PS_W : PROD_I_W) + 1;
  localparam int NUM5_W     = NUM_W + 3;
  localparam int SHIFT      = GAIN_FRAC + WIN_LOG2;
  localparam int DRIVE_W    = NUM5_W - SHIFT;

  // Pipeline: window, products, sum, scale, divide, decide/output.
  localparam int NUM_STAGES = 6;
  localparam int ST_WIN     = 0;
  localparam int ST_PROD    = 1;
  localparam int ST_NUM     = 2;
  localparam int ST_NUM5    = 3;
  localparam int ST_DRIVE   = 4;
  localparam int ST_OUT     = 5;

  // Configuration register indexes.
  localparam int CFG_ADDR_W = 3;
  localparam logic [CFG_ADDR_W-1:0] REG_SETPOINT   = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_PROP_GAIN  = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_INTEG_GAIN = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_DEADBAND   = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_HEAT_MODE  = 3'd4;

  localparam logic [DATA_W-1:0] POS_MAX = {DATA_W{1'b1}};

  typedef enum logic [1:0] {
    CMD_NONE = 2'd0,
    CMD_GOTO = 2'd1,
    CMD_HOME = 2'd2
  } cmd_t;

  typedef struct packed {
    logic [DATA_W-1:0] setpoint;
    logic [DATA_W-1:0] prop_gain;
    logic [DATA_W-1:0] integ_gain;
    logic [DATA_W-1:0] deadband;
    logic              heat_mode;
  } wpvc_cfg_t;

  typedef struct packed {
    logic [NUM_STAGES-1:0] adv;
    logic                  accept;
    logic                  in_ready;
    logic                  out_valid;
  } wpvc_pipe_t;

endpackage

/* design/wpvc_pipe_ctrl.sv */
// ----------------------------------------------------------------------------
// wpvc_pipe_ctrl
// Valid bits and ready chain of the pipeline; a stage loads when it is empty
// or when the stage after it moves on.
// ----------------------------------------------------------------------------
module wpvc_pipe_ctrl
  import wpvc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       out_ready,
  output wpvc_pipe_t pipe
);

  logic [NUM_STAGES-1:0] valid_r;
  logic [NUM_STAGES-1:0] valid_nxt;
  logic [NUM_STAGES:0]   ready;

  always_comb begin
    ready[NUM_STAGES] = out_ready;
    for (int k = NUM_STAGES - 1; k >= 0; k--) begin
      ready[k] = !valid_r[k] || ready[k+1];
    end
  end

  always_comb begin
    for (int k = 0; k < NUM_STAGES; k++) begin
      if (ready[k]) begin
        valid_nxt[k] = (k == 0) ? in_valid : valid_r[(k == 0) ? 0 : k - 1];
      end else begin
        valid_nxt[k] = valid_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign pipe.adv       = ready[NUM_STAGES-1:0];
  assign pipe.accept    = in_valid && ready[0];
  assign pipe.in_ready  = ready[0];
  assign pipe.out_valid = valid_r[ST_OUT];

endmodule

/* design/wpvc_error_window.sv */
// ----------------------------------------------------------------------------
// wpvc_error_window
// Error against setpoint, ring of the last errors and their running sum.
// ----------------------------------------------------------------------------
module wpvc_error_window
  import wpvc_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  wpvc_pipe_t              pipe,
  input  wpvc_cfg_t               cfg,
  input  logic [DATA_W-1:0]       temperature,
  output logic signed [ERR_W-1:0] err,
  output logic signed [SUM_W-1:0] err_sum
);

  logic signed [ERR_W-1:0] ring_r [WINDOW_LEN];
  logic [IDX_W-1:0]        idx_r;
  logic signed [SUM_W-1:0] sum_r;
  logic signed [ERR_W-1:0] err_nxt;
  logic signed [SUM_W-1:0] sum_nxt;
  logic signed [ERR_W-1:0] err_r;
  logic signed [SUM_W-1:0] win_sum_r;

  assign err_nxt = $signed({1'b0, temperature}) - $signed({1'b0, cfg.setpoint});
  // drop the oldest error, add the new one
  assign sum_nxt = sum_r - SUM_W'(ring_r[idx_r]) + SUM_W'(err_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      sum_r <= '0;
      for (int i = 0; i < WINDOW_LEN; i++) begin
        ring_r[i] <= '0;
      end
    end else if (pipe.accept) begin
      ring_r[idx_r] <= err_nxt;
      idx_r         <= idx_r + IDX_W'(1);
      sum_r         <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe.adv[ST_WIN]) begin
      err_r     <= err_nxt;
      win_sum_r <= sum_nxt;
    end
  end

  assign err     = err_r;
  assign err_sum = win_sum_r;

endmodule

/* design/wpvc_drive_calc.sv */
// ----------------------------------------------------------------------------
// wpvc_drive_calc
// Drive value 5*(err*kp*N + sum*ki) / (256*N), truncated toward zero.
// ----------------------------------------------------------------------------
module wpvc_drive_calc
  import wpvc_pkg::*;
(
  input  logic                      clk,
  input  wpvc_pipe_t                pipe,
  input  wpvc_cfg_t                 cfg,
  input  logic signed [ERR_W-1:0]   err,
  input  logic signed [SUM_W-1:0]   err_sum,
  output logic signed [DRIVE_W-1:0] drive
);

  localparam logic [NUM5_W-1:0] DIV_BIAS = NUM5_W'({SHIFT{1'b1}});

  logic signed [PROD_P_W-1:0] prod_p_r;
  logic signed [PROD_I_W-1:0] prod_i_r;
  logic signed [NUM_W-1:0]    num_r;
  logic signed [NUM5_W-1:0]   num5_r;
  logic signed [DRIVE_W-1:0]  drive_r;
  logic signed [PROD_P_W-1:0] prod_p_nxt;
  logic signed [PROD_I_W-1:0] prod_i_nxt;
  logic signed [NUM_W-1:0]    num_nxt;
  logic signed [NUM5_W-1:0]   num5_nxt;
  logic signed [NUM5_W-1:0]   biased;

  assign prod_p_nxt = PROD_P_W'(err * $signed({1'b0, cfg.prop_gain}));
  assign prod_i_nxt = PROD_I_W'(err_sum * $signed({1'b0, cfg.integ_gain}));

  assign num_nxt  = (NUM_W'(prod_p_r) <<< WIN_LOG2) + NUM_W'(prod_i_r);
  assign num5_nxt = (NUM5_W'(num_r) <<< 2) + NUM5_W'(num_r);

  // round a negative quotient up so the shift truncates toward zero
  assign biased = num5_r + (num5_r[NUM5_W-1] ? $signed(DIV_BIAS) : $signed(NUM5_W'(0)));

  always_ff @(posedge clk) begin
    if (pipe.adv[ST_PROD]) begin
      prod_p_r <= prod_p_nxt;
      prod_i_r <= prod_i_nxt;
    end
    if (pipe.adv[ST_NUM]) begin
      num_r <= num_nxt;
    end
    if (pipe.adv[ST_NUM5]) begin
      num5_r <= num5_nxt;
    end
    if (pipe.adv[ST_DRIVE]) begin
      drive_r <= biased[NUM5_W-1:SHIFT];
    end
  end

  assign drive = drive_r;

endmodule

/* design/wpvc_valve_decide.sv */
// ----------------------------------------------------------------------------
// wpvc_valve_decide
// Deadband, mode and saturation; holds the result register.
// ----------------------------------------------------------------------------
module wpvc_valve_decide
  import wpvc_pkg::*;
(
  input  logic                      clk,
  input  wpvc_pipe_t                pipe,
  input  wpvc_cfg_t                 cfg,
  input  logic signed [DRIVE_W-1:0] drive,
  output cmd_t                      command,
  output logic [DATA_W-1:0]         position
);

  logic                     neg;
  logic                     zero;
  logic [DRIVE_W-1:0]       mag;
  logic [DATA_W-1:0]        pos_sat;
  logic                     toward;
  cmd_t                     cmd_nxt;
  logic [DATA_W-1:0]        pos_nxt;
  cmd_t                     cmd_r;
  logic [DATA_W-1:0]        pos_r;

  assign neg  = drive[DRIVE_W-1];
  assign zero = (drive == '0);
  assign mag  = neg ? DRIVE_W'(-drive) : DRIVE_W'(drive);
  assign pos_sat = (mag > DRIVE_W'(POS_MAX)) ? POS_MAX : mag[DATA_W-1:0];
  // drive in the direction this valve acts on
  assign toward = cfg.heat_mode ? neg : (!neg && !zero);

  always_comb begin
    cmd_nxt = CMD_NONE;
    pos_nxt = '0;
    if (mag >= DRIVE_W'(cfg.deadband)) begin
      if (toward) begin
        cmd_nxt = CMD_GOTO;
        pos_nxt = pos_sat;
      end else begin
        cmd_nxt = CMD_HOME;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pipe.adv[ST_OUT]) begin
      cmd_r <= cmd_nxt;
      pos_r <= pos_nxt;
    end
  end

  assign command  = cmd_r;
  assign position = pos_r;

endmodule

/* design/windowed_pi_valve_controller.sv */
// ----------------------------------------------------------------------------
// windowed_pi_valve_controller
// PI valve controller with a moving-window integral term.
// ----------------------------------------------------------------------------
// Takes one temperature request per cycle while the result side keeps
// taking commands, and returns one valve command per request. The
// pipeline runs: error and window update, the two gain multiplies,
// their sum, the scale by five, the truncating divide, then the
// deadband/mode decision into the result register. Each stage has its
// own valid bit, so a stalled result only holds the stages that are
// full: requests keep entering into any empty stage.
// The error window is a ring of eight registers cleared by reset together
// with the running sum, so there is no clearing pass after reset.
// Configuration writes take effect at the next clock edge; change settings
// only while no request is in flight.
// ----------------------------------------------------------------------------
module windowed_pi_valve_controller
  import wpvc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // in_tdata: [15:0] temperature
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [15:0]           in_tdata,
  // out_tdata: [1:0] command, [17:2] position, [23:18] zero
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [23:0]           out_tdata,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [DATA_W-1:0]     cfg_wdata
);

  wpvc_cfg_t               cfg_r;
  wpvc_pipe_t              pipe;
  logic signed [ERR_W-1:0]   err;
  logic signed [SUM_W-1:0]   err_sum;
  logic signed [DRIVE_W-1:0] drive;
  cmd_t                    command;
  logic [DATA_W-1:0]       position;

  // register file; writes beyond the last index are ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_SETPOINT:   cfg_r.setpoint   <= cfg_wdata;
        REG_PROP_GAIN:  cfg_r.prop_gain  <= cfg_wdata;
        REG_INTEG_GAIN: cfg_r.integ_gain <= cfg_wdata;
        REG_DEADBAND:   cfg_r.deadband   <= cfg_wdata;
        REG_HEAT_MODE:  cfg_r.heat_mode  <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  wpvc_pipe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .out_ready (out_tready),
    .pipe      (pipe)
  );

  wpvc_error_window u_window (
    .clk         (clk),
    .rst_n       (rst_n),
    .pipe        (pipe),
    .cfg         (cfg_r),
    .temperature (in_tdata),
    .err         (err),
    .err_sum     (err_sum)
  );

  wpvc_drive_calc u_drive (
    .clk     (clk),
    .pipe    (pipe),
    .cfg     (cfg_r),
    .err     (err),
    .err_sum (err_sum),
    .drive   (drive)
  );

  wpvc_valve_decide u_decide (
    .clk      (clk),
    .pipe     (pipe),
    .cfg      (cfg_r),
    .drive    (drive),
    .command  (command),
    .position (position)
  );

  assign in_tready  = pipe.in_ready;
  assign out_tvalid = pipe.out_valid;
  assign out_tdata  = {6'd0, position, command};

endmodule

/* test/tb_windowed_pi_valve_controller.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_windowed_pi_valve_controller
// Self-checking bench for the windowed PI valve controller.
// ----------------------------------------------------------------------------
// Streams temperature requests into the block under a series of register
// settings and checks every valve command that comes back. Directed edge cases
// come first under fixed settings, then random settings with random requests
// follow. Both stream sides idle at random. One phase runs with no idling at
// all. In another phase the result side holds off for a long stretch, so the
// pipeline fills and stalls its input. A scoreboard object keeps its own copy
// of the error window and the registers. It predicts one command per accepted
// request and compares the commands in order.
// ----------------------------------------------------------------------------
module tb_windowed_pi_valve_controller;
  import wpvc_pkg::*;

  localparam int CLK_HALF     = 10;
  localparam int RST_CYCLES   = 6;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int RAND_PHASES  = 12;
  localparam int PHASE_ITEMS  = 96;
  localparam int HOLD_CYCLES  = 300;
  localparam int QUIET_PHASE  = 2;
  localparam int HOLD_PHASE   = 5;
  localparam int IDLE_PCT     = 37;

  // Expected valve command for one temperature request.
  typedef struct {
    cmd_t              cmd;
    logic [DATA_W-1:0] pos;
  } valve_cmd_t;

  // Scoreboard: mirrors the controller state and queues predicted commands.
  class valve_cmd_board;
    logic [DATA_W-1:0] setpoint;
    logic [DATA_W-1:0] prop_gain;
    logic [DATA_W-1:0] integ_gain;
    logic [DATA_W-1:0] deadband;
    logic              heat_mode;
    longint            err_ring[WINDOW_LEN];
    int unsigned       slot;
    longint            err_sum;
    valve_cmd_t        pending_cmds[$];
    int                fail_cnt;

    function new();
      setpoint   = '0;
      prop_gain  = '0;
      integ_gain = '0;
      deadband   = '0;
      heat_mode  = 1'b0;
      foreach (err_ring[i]) err_ring[i] = 0;
      slot     = 0;
      err_sum  = 0;
      fail_cnt = 0;
    endfunction

    function void set_reg(logic [CFG_ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
      case (addr)
        REG_SETPOINT:   setpoint   = data;
        REG_PROP_GAIN:  prop_gain  = data;
        REG_INTEG_GAIN: integ_gain = data;
        REG_DEADBAND:   deadband   = data;
        REG_HEAT_MODE:  heat_mode  = data[0];
        default: ;
      endcase
    endfunction

    // Update the error window and predict the command for one sample.
    function void take_sample(logic [DATA_W-1:0] temp);
      longint     err;
      longint     num;
      longint     drive;
      longint     mag;
      longint     want;
      valve_cmd_t c;
      err = longint'(temp) - longint'(setpoint);
      err_sum = err_sum - err_ring[slot] + err;
      err_ring[slot] = err;
      slot = (slot + 1 >= WINDOW_LEN) ? 0 : slot + 1;

      num   = err * longint'(prop_gain) * WINDOW_LEN + err_sum * longint'(integ_gain);
      drive = (num * 5) / (longint'(256) * WINDOW_LEN);
      mag   = (drive < 0) ? -drive : drive;

      c.cmd = CMD_NONE;
      c.pos = '0;
      if (mag >= longint'(deadband)) begin
        want = heat_mode ? -drive : drive;
        if (want > 0) begin
          c.cmd = CMD_GOTO;
          c.pos = (want > longint'(POS_MAX)) ? POS_MAX : want[DATA_W-1:0];
        end else begin
          c.cmd = CMD_HOME;
        end
      end
      pending_cmds.push_back(c);
    endfunction

    function void check_command(logic [23:0] d);
      valve_cmd_t e;
      if (pending_cmds.size() == 0) begin
        $error("unexpected command: tdata %h with nothing pending", d);
        fail_cnt++;
        return;
      end
      e = pending_cmds.pop_front();
      if (d[1:0] != e.cmd) begin
        $error("command: expected %0d, actual %0d", e.cmd, d[1:0]);
        fail_cnt++;
      end
      if (d[17:2] != e.pos) begin
        $error("position: expected %0d, actual %0d", e.pos, d[17:2]);
        fail_cnt++;
      end
      if (d[23:18] != '0) begin
        $error("pad: expected 0, actual %0h", d[23:18]);
        fail_cnt++;
      end
    endfunction

    function int pending();
      return pending_cmds.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [15:0]           in_tdata   = '0;   // [15:0] temperature
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [23:0]           out_tdata;         // [1:0] command, [17:2] position, [23:18] zero
  logic                  cfg_we     = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr   = '0;
  logic [DATA_W-1:0]     cfg_wdata  = '0;

  logic        hold_req = 1'b0;
  logic        hold_off = 1'b0;
  int          idle_pct = IDLE_PCT;
  int unsigned cycle_cnt;

  valve_cmd_board sb = new();

  windowed_pi_valve_controller uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Watchdog: end the run as failed if it never drains.
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("windowed_pi_valve_controller: mismatch");
    $finish;
  end

  // Result side: check each accepted command, then pick ready for the next
  // edge. Drop ready completely while a hold-off is running.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_command(out_tdata);
    if (hold_off) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= idle_pct);
    end
  end

  // Hold-off: once requested, keep the result side stalled for a long count
  // of cycles while the sender keeps pushing requests.
  initial begin : pressure
    int n;
    while (!hold_req) @(posedge clk);
    hold_off <= 1'b1;
    for (n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
    hold_off <= 1'b0;
  end

  // Offer one temperature request, with random idle cycles ahead of it, and
  // hold it until accepted. The sender never idles during a hold-off.
  task automatic send_temp(input logic [DATA_W-1:0] t);
    while (!hold_off && $urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= t;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.take_sample(t);
  endtask

  // Stop offering and wait until every predicted command has come back.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Keep cfg_we high across back-to-back writes; program_regs lowers it.
  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    @(posedge clk);
    sb.set_reg(addr, data);
  endtask

  // Write all registers. Junk rides in the upper bits of heat_mode. A write
  // to an unused index follows and must leave every register untouched.
  task automatic program_regs(input logic [DATA_W-1:0] sp, input logic [DATA_W-1:0] pg,
                              input logic [DATA_W-1:0] ig, input logic [DATA_W-1:0] db,
                              input logic hm);
    write_reg(REG_SETPOINT, sp);
    write_reg(REG_PROP_GAIN, pg);
    write_reg(REG_INTEG_GAIN, ig);
    write_reg(REG_DEADBAND, db);
    write_reg(REG_HEAT_MODE, {15'($urandom), hm});
    write_reg(CFG_ADDR_W'($urandom_range(7, 5)), 16'($urandom));
    cfg_we <= 1'b0;
  endtask

  function automatic logic [DATA_W-1:0] pick_gain();
    case ($urandom_range(19))
      0, 1, 2:       return '0;
      3, 4, 5:       return POS_MAX;
      6, 7, 8, 9, 10, 11, 12, 13: return 16'($urandom_range(16'h0400));
      default:       return 16'($urandom);
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] pick_deadband();
    case ($urandom_range(9))
      0, 1, 2:    return '0;
      3, 4, 5, 6: return 16'($urandom_range(2000));
      7:          return POS_MAX;
      default:    return 16'($urandom);
    endcase
  endfunction

  // Mostly stay near the setpoint so the deadband and both signs show up.
  function automatic logic [DATA_W-1:0] pick_temp(input logic [DATA_W-1:0] sp);
    int v;
    case ($urandom_range(9))
      0, 1, 2, 3, 4: v = int'(sp) + $urandom_range(512) - 256;
      5, 6, 7:       v = $urandom_range(16'hFFFF);
      8:             v = $urandom_range(1) ? 16'hFFFF : 0;
      default:       v = int'(sp);
    endcase
    if (v < 0) v = 0;
    if (v > 16'hFFFF) v = 16'hFFFF;
    return 16'(v);
  endfunction

  initial begin : stimulus
    int                ph;
    int                k;
    logic [DATA_W-1:0] sp;

    repeat (RST_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: all gains zero, so the drive is zero and a zero
    // deadband lets it through as a close.
    send_temp(16'h0000);
    send_temp(16'hFFFF);
    wait_drained();

    // Unity proportional gain, add-cold: open, close, saturate, zero drive.
    program_regs(16'h8000, 16'h0100, 16'h0000, 16'h0000, 1'b0);
    send_temp(16'd40000);
    send_temp(16'h0000);
    send_temp(16'hFFFF);
    send_temp(16'h8000);
    wait_drained();

    // Add-heat with a deadband: suppressed, saturate, open, close.
    program_regs(16'h8000, 16'h0100, 16'h0000, 16'd1000, 1'b1);
    send_temp(16'd32868);
    send_temp(16'h0000);
    send_temp(16'd30000);
    send_temp(16'hFFFF);
    wait_drained();

    // Gains and deadband at their maximum, setpoint at zero.
    program_regs(16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
    send_temp(16'hFFFF);
    send_temp(16'h0000);
    send_temp(16'h0001);
    send_temp(16'h0000);
    wait_drained();

    // Integral term alone, heat mode, setpoint at the top.
    program_regs(16'hFFFF, 16'h0000, 16'h0080, 16'h0001, 1'b1);
    send_temp(16'h0000);
    send_temp(16'h0000);
    send_temp(16'h1234);
    send_temp(16'hFFFF);
    send_temp(16'hFFFF);
    wait_drained();

    for (ph = 0; ph < RAND_PHASES; ph++) begin
      sp = $urandom_range(3) == 0 ? ($urandom_range(1) ? POS_MAX : 16'h0000)
                                  : 16'($urandom);
      program_regs(sp, pick_gain(), pick_gain(), pick_deadband(), 1'($urandom));
      idle_pct = (ph == QUIET_PHASE) ? 0 : IDLE_PCT;
      if (ph == HOLD_PHASE) hold_req <= 1'b1;
      for (k = 0; k < PHASE_ITEMS; k++) send_temp(pick_temp(sp));
      wait_drained();
    end
    idle_pct = IDLE_PCT;

    // Let any stray command show up before the verdict.
    repeat (3 * NUM_STAGES) @(posedge clk);
    if (sb.fail_cnt == 0 && sb.pending() == 0) begin
      $display("windowed_pi_valve_controller: match");
    end else begin
      $display("windowed_pi_valve_controller: mismatch");
    end
    $finish;
  end

endmodule

/* sim.f */
design/wpvc_pkg.sv
design/wpvc_pipe_ctrl.sv
design/wpvc_error_window.sv
design/wpvc_drive_calc.sv
design/wpvc_valve_decide.sv
design/windowed_pi_valve_controller.sv
test/tb_windowed_pi_valve_controller.sv
